### rtl/text_command_packet_parser_defines.svh
// Assertion helpers shared by the RTL; each expects clk and arst_n in scope.
`ifndef TEXT_COMMAND_PACKET_PARSER_DEFINES_SVH
`define TEXT_COMMAND_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TCPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tcpp_pkg.sv
package tcpp_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        mode_now;
		logic [15:0] heartbeat_rate;
	} out_item_t;

	localparam logic [2:0] PH_COMMAND = 3'd0;
	localparam logic [2:0] PH_UUID    = 3'd1;
	localparam logic [2:0] PH_VALUE   = 3'd2;
	localparam logic [2:0] PH_PREFIX  = 3'd3;
	localparam logic [2:0] PH_VERSION = 3'd4;

	localparam logic [1:0] VS_MAJOR      = 2'd0;
	localparam logic [1:0] VS_MAJOR_DONE = 2'd1;
	localparam logic [1:0] VS_MINOR      = 2'd2;
	localparam logic [1:0] VS_MINOR_DONE = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_PARSE    = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	localparam logic MODE_ROTATION  = 1'b0;
	localparam logic MODE_HEARTBEAT = 1'b1;

	localparam logic [15:0] HEARTBEAT_SET_VALUE = 16'd100;
	localparam logic [8:0]  NUM_LIMIT  = 9'd256;
	localparam logic [2:0]  CMD_LEN    = 3'd4;
	localparam logic [2:0]  LEN_SAT    = 3'd5;
	localparam logic [2:0]  PREFIX_LEN = 3'd4;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	localparam logic [31:0] CMD_LIST = 32'h4C49_5354;
	localparam logic [31:0] CMD_GETV = 32'h4745_5456;
	localparam logic [31:0] CMD_GETM = 32'h4745_544D;
	localparam logic [31:0] CMD_GETP = 32'h4745_5450;
	localparam logic [31:0] CMD_SETV = 32'h5345_5456;
	localparam logic [31:0] CMD_SETM = 32'h5345_544D;
	localparam logic [31:0] CMD_SETP = 32'h5345_5450;

	localparam logic [0:0] CFG_VERSION_MAJOR = 1'd0;
	localparam logic [0:0] CFG_VERSION_MINOR = 1'd1;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] cmd;
		logic [2:0]  tok_len;
		logic [2:0]  prefix_idx;
		logic [8:0]  major;
		logic [8:0]  minor;
		logic [1:0]  vsub;
		logic        err;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase: PH_COMMAND, cmd: 32'd0, tok_len: 3'd0, prefix_idx: 3'd0,
		major: 9'd0, minor: 9'd0, vsub: VS_MAJOR, err: 1'b0
	};

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	// acc * 10 + digit, clamped at NUM_LIMIT
	function automatic logic [8:0] accumulate(input logic [8:0] acc, input logic [7:0] c);
		logic [11:0] v;
		v = {3'b000, acc} * 12'd10 + {8'h00, c[3:0]};
		return (v > {3'b000, NUM_LIMIT}) ? NUM_LIMIT : v[8:0];
	endfunction

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		case (idx)
			2'd0: return 8'h53;
			2'd1: return 8'h49;
			2'd2: return 8'h58;
			default: return 8'h2F;
		endcase
	endfunction

endpackage

### rtl/text_command_packet_parser.sv
// A word with last_char set shows its result on out_valid in the cycle after acceptance.
// Throughput: one word per cycle while in_ready is high; the parse state advances in a single step per character.
// in_ready drops only while a finished result waits in the output register.
// Reset (arst_n low, asynchronous): parse state clears, mode is rotation, heartbeat rate 0,
// expected version is 0.1, no result pending.
`include "text_command_packet_parser_defines.svh"

module text_command_packet_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcpp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tcpp_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	// Parse state, stored settings and the expected version.
	tcpp_pkg::parse_state_t state_q;
	logic                   mode_q;
	logic [15:0]            hb_q;
	logic [7:0]             ver_major_q;
	logic [7:0]             ver_minor_q;

	// Output register: holds a finished status until the consumer takes it.
	tcpp_pkg::out_item_t    out_q;
	logic                   out_valid_q;

	tcpp_pkg::parse_state_t state_nxt;
	logic                   mode_nxt;
	logic [15:0]            hb_nxt;
	logic [1:0]             status_nxt;
	logic                   in_fire;

	// Accept a word whenever the output slot is free or drains this cycle.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tcpp_step u_step (
		.cur       (state_q),
		.mode_cur  (mode_q),
		.hb_cur    (hb_q),
		.char_byte (in_data.char_byte),
		.last_char (in_data.last_char),
		.ver_major (ver_major_q),
		.ver_minor (ver_minor_q),
		.nxt       (state_nxt),
		.mode_nxt  (mode_nxt),
		.hb_nxt    (hb_nxt),
		.status    (status_nxt)
	);

	// Configuration writes land directly; the host must write only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_major_q <= 8'd0;
			ver_minor_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				tcpp_pkg::CFG_VERSION_MAJOR: ver_major_q <= cfg_data;
				tcpp_pkg::CFG_VERSION_MINOR: ver_minor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the parser by one character per accepted word; the step logic
	// already returns the cleared state at packet end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpp_pkg::PARSE_RESET;
			mode_q  <= tcpp_pkg::MODE_ROTATION;
			hb_q    <= 16'd0;
		end else if (in_fire) begin
			state_q <= state_nxt;
			mode_q  <= mode_nxt;
			hb_q    <= hb_nxt;
		end
	end

	// Result valid: set on a packet end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && in_data.last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: capture status together with the updated settings.
	always_ff @(posedge clk) begin
		if (in_fire && in_data.last_char) begin
			out_q <= '{status: status_nxt, mode_now: mode_nxt, heartbeat_rate: hb_nxt};
		end
	end

	`TCPP_ASSERT_NEXT(a_last_gives_result, in_fire && in_data.last_char, out_valid_q, "packet end produced no result")
	`TCPP_ASSERT_NOW(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready, "word accepted while result is stalled")
	`TCPP_ASSERT_NEXT(a_last_clears_parse, in_fire && in_data.last_char, state_q.phase == tcpp_pkg::PH_COMMAND && !state_q.err && state_q.tok_len == 3'd0, "parse state not cleared after packet end")
	`TCPP_ASSERT_NOW(a_version_after_prefix, state_q.phase == tcpp_pkg::PH_VERSION, state_q.prefix_idx == tcpp_pkg::PREFIX_LEN, "version phase entered without full prefix")
	`TCPP_ASSERT_NOW(a_status_code_valid, out_valid_q, out_q.status != 2'd3, "undefined status code")

endmodule

### rtl/tcpp_step.sv
module tcpp_step (
	input  tcpp_pkg::parse_state_t cur,
	input  logic                   mode_cur,
	input  logic [15:0]            hb_cur,
	input  logic [7:0]             char_byte,
	input  logic                   last_char,
	input  logic [7:0]             ver_major,
	input  logic [7:0]             ver_minor,
	output tcpp_pkg::parse_state_t nxt,
	output logic                   mode_nxt,
	output logic [15:0]            hb_nxt,
	output logic [1:0]             status
);

	tcpp_pkg::parse_state_t p;
	logic                   is_space;
	logic                   is_digit;
	logic [7:0]             up;

	assign is_space = (char_byte == tcpp_pkg::CHAR_SPACE);
	assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
	assign up       = tcpp_pkg::upcase(char_byte);

	always_comb begin
		p        = cur;
		mode_nxt = mode_cur;
		hb_nxt   = hb_cur;
		if (!cur.err) begin
			case (cur.phase)
				tcpp_pkg::PH_COMMAND: begin
					if (!is_space) begin
						if (cur.tok_len < tcpp_pkg::CMD_LEN) begin
							p.cmd = {cur.cmd[23:0], up};
						end
						if (cur.tok_len < tcpp_pkg::LEN_SAT) begin
							p.tok_len = cur.tok_len + 3'd1;
						end
					end else if (cur.tok_len != tcpp_pkg::CMD_LEN) begin
						p.err = 1'b1;
					end else begin
						p.tok_len = 3'd0;
						p.phase   = (cur.cmd == tcpp_pkg::CMD_LIST) ?
							tcpp_pkg::PH_PREFIX : tcpp_pkg::PH_UUID;
					end
				end
				tcpp_pkg::PH_UUID, tcpp_pkg::PH_VALUE: begin
					if (!is_space) begin
						if (cur.tok_len < tcpp_pkg::LEN_SAT) begin
							p.tok_len = cur.tok_len + 3'd1;
						end
					end else if (cur.tok_len == 3'd0) begin
						p.err = 1'b1;
					end else begin
						p.tok_len = 3'd0;
						p.phase   = tcpp_pkg::PH_PREFIX;
						if (cur.phase == tcpp_pkg::PH_UUID) begin
							if (cur.cmd == tcpp_pkg::CMD_GETV) begin
								if (mode_cur == tcpp_pkg::MODE_HEARTBEAT) begin
									hb_nxt = tcpp_pkg::HEARTBEAT_SET_VALUE;
								end
							end else if (cur.cmd == tcpp_pkg::CMD_GETM) begin
								mode_nxt = tcpp_pkg::MODE_ROTATION;
							end else if (cur.cmd == tcpp_pkg::CMD_GETP) begin
								mode_nxt = tcpp_pkg::MODE_HEARTBEAT;
							end else begin
								p.phase = tcpp_pkg::PH_VALUE;
							end
						end else begin
							if (cur.cmd == tcpp_pkg::CMD_SETV) begin
								if (mode_cur == tcpp_pkg::MODE_ROTATION) begin
									hb_nxt = tcpp_pkg::HEARTBEAT_SET_VALUE;
								end
							end else if (cur.cmd == tcpp_pkg::CMD_SETM ||
									cur.cmd == tcpp_pkg::CMD_SETP) begin
								mode_nxt = tcpp_pkg::MODE_ROTATION;
							end
						end
					end
				end
				tcpp_pkg::PH_PREFIX: begin
					if (up != tcpp_pkg::prefix_char(cur.prefix_idx[1:0])) begin
						p.err = 1'b1;
					end else begin
						p.prefix_idx = cur.prefix_idx + 3'd1;
						if (p.prefix_idx >= tcpp_pkg::PREFIX_LEN) begin
							p.phase = tcpp_pkg::PH_VERSION;
							p.vsub  = tcpp_pkg::VS_MAJOR;
						end
					end
				end
				tcpp_pkg::PH_VERSION: begin
					if (cur.vsub == tcpp_pkg::VS_MAJOR || cur.vsub == tcpp_pkg::VS_MAJOR_DONE) begin
						if (char_byte == tcpp_pkg::CHAR_DOT) begin
							p.vsub = tcpp_pkg::VS_MINOR;
						end else if (cur.vsub == tcpp_pkg::VS_MAJOR && is_digit) begin
							p.major = tcpp_pkg::accumulate(cur.major, char_byte);
						end else begin
							p.vsub = tcpp_pkg::VS_MAJOR_DONE;
						end
					end else if (cur.vsub == tcpp_pkg::VS_MINOR) begin
						if (is_digit) begin
							p.minor = tcpp_pkg::accumulate(cur.minor, char_byte);
						end else begin
							p.vsub = tcpp_pkg::VS_MINOR_DONE;
						end
					end
				end
				default: begin
					p.err = 1'b1;
				end
			endcase
		end

		// verdict on the state after this character
		if (p.err || p.phase != tcpp_pkg::PH_VERSION || p.vsub < tcpp_pkg::VS_MINOR) begin
			status = tcpp_pkg::STATUS_PARSE;
		end else if (p.major != {1'b0, ver_major} || p.minor != {1'b0, ver_minor}) begin
			status = tcpp_pkg::STATUS_MISMATCH;
		end else begin
			status = tcpp_pkg::STATUS_OK;
		end

		nxt = last_char ? tcpp_pkg::PARSE_RESET : p;
	end

endmodule

### dv/tb_text_command_packet_parser.sv
module tb_text_command_packet_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpp_pkg::*;

	// Protocol prefix bytes in packet order, most significant byte first.
	localparam logic [31:0] PROTO_PREFIX = 32'h5349_582F;
	// Characters sent per configuration phase before the phase closes.
	localparam int PHASE_CHARS = 290;

	// Predicts the status word of every packet and holds the expected words in order.
	// Its parse state mirrors the block character by character and restarts after each
	// packet; mode, rate and the expected version persist across packets.
	class packet_status_checker;
		logic [7:0]  exp_major;
		logic [7:0]  exp_minor;
		logic [2:0]  stage;
		logic [31:0] cmd_word;
		logic [2:0]  tok_cnt;
		logic [2:0]  pfx_pos;
		logic [8:0]  major_acc;
		logic [8:0]  minor_acc;
		logic [1:0]  ver_step;
		logic        bad;
		logic        mode;
		logic [15:0] rate;
		out_item_t   expected_status[$];
		int          failures;

		function new();
			exp_major = 8'd0;
			exp_minor = 8'd1;
			mode = MODE_ROTATION;
			rate = 16'd0;
			failures = 0;
			restart();
		endfunction

		function void restart();
			stage = PH_COMMAND;
			cmd_word = 32'd0;
			tok_cnt = 3'd0;
			pfx_pos = 3'd0;
			major_acc = 9'd0;
			minor_acc = 9'd0;
			ver_step = VS_MAJOR;
			bad = 1'b0;
		endfunction

		function void set_version(logic [0:0] idx, logic [7:0] v);
			if (idx == CFG_VERSION_MAJOR) begin
				exp_major = v;
			end else begin
				exp_minor = v;
			end
		endfunction

		function logic [7:0] fold_case(logic [7:0] c);
			if (c >= 8'h61 && c <= 8'h7A) begin
				return c - 8'h20;
			end
			return c;
		endfunction

		// Decimal accumulate, pinned at the saturation value.
		function logic [8:0] add_digit(logic [8:0] acc, logic [7:0] c);
			int v;
			v = int'(acc) * 10 + int'(c) - 48;
			return (v > int'(NUM_LIMIT)) ? NUM_LIMIT : v[8:0];
		endfunction

		function void take_char(logic [7:0] c);
			logic is_space;
			logic is_digit;
			is_space = (c == CHAR_SPACE);
			is_digit = (c >= 8'h30 && c <= 8'h39);
			case (stage)
				PH_COMMAND: begin
					if (!is_space) begin
						if (tok_cnt < CMD_LEN) begin
							cmd_word = {cmd_word[23:0], fold_case(c)};
						end
						if (tok_cnt < LEN_SAT) tok_cnt++;
					end else if (tok_cnt != CMD_LEN) begin
						bad = 1'b1;
					end else begin
						tok_cnt = 3'd0;
						stage = (cmd_word == CMD_LIST) ? PH_PREFIX : PH_UUID;
					end
				end
				PH_UUID: begin
					if (!is_space) begin
						if (tok_cnt < LEN_SAT) tok_cnt++;
					end else if (tok_cnt == 3'd0) begin
						bad = 1'b1;
					end else begin
						tok_cnt = 3'd0;
						stage = PH_PREFIX;
						if (cmd_word == CMD_GETV) begin
							if (mode == MODE_HEARTBEAT) rate = HEARTBEAT_SET_VALUE;
						end else if (cmd_word == CMD_GETM) begin
							mode = MODE_ROTATION;
						end else if (cmd_word == CMD_GETP) begin
							mode = MODE_HEARTBEAT;
						end else begin
							stage = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					if (!is_space) begin
						if (tok_cnt < LEN_SAT) tok_cnt++;
					end else if (tok_cnt == 3'd0) begin
						bad = 1'b1;
					end else begin
						tok_cnt = 3'd0;
						stage = PH_PREFIX;
						if (cmd_word == CMD_SETV) begin
							if (mode == MODE_ROTATION) rate = HEARTBEAT_SET_VALUE;
						end else if (cmd_word == CMD_SETM || cmd_word == CMD_SETP) begin
							mode = MODE_ROTATION;
						end
					end
				end
				PH_PREFIX: begin
					if (fold_case(c) != PROTO_PREFIX[31 - 8 * pfx_pos[1:0] -: 8]) begin
						bad = 1'b1;
					end else begin
						pfx_pos++;
						if (pfx_pos >= PREFIX_LEN) begin
							stage = PH_VERSION;
							ver_step = VS_MAJOR;
						end
					end
				end
				PH_VERSION: begin
					if (ver_step == VS_MAJOR || ver_step == VS_MAJOR_DONE) begin
						if (c == CHAR_DOT) begin
							ver_step = VS_MINOR;
						end else if (ver_step == VS_MAJOR && is_digit) begin
							major_acc = add_digit(major_acc, c);
						end else begin
							ver_step = VS_MAJOR_DONE;
						end
					end else if (ver_step == VS_MINOR) begin
						if (is_digit) begin
							minor_acc = add_digit(minor_acc, c);
						end else begin
							ver_step = VS_MINOR_DONE;
						end
					end
				end
				default: bad = 1'b1;
			endcase
		endfunction

		function void note_char(in_item_t w);
			out_item_t r;
			if (!bad) take_char(w.char_byte);
			if (w.last_char) begin
				if (bad || stage != PH_VERSION || ver_step < VS_MINOR) begin
					r.status = STATUS_PARSE;
				end else if (major_acc != {1'b0, exp_major} || minor_acc != {1'b0, exp_minor}) begin
					r.status = STATUS_MISMATCH;
				end else begin
					r.status = STATUS_OK;
				end
				r.mode_now = mode;
				r.heartbeat_rate = rate;
				expected_status.push_back(r);
				restart();
			end
		endfunction

		function void check_status(out_item_t got);
			out_item_t want;
			if (expected_status.size() == 0) begin
				failures++;
				$display("%0t ns: result with none expected, actual status %0d mode %0d rate %0d",
					$time, got.status, got.mode_now, got.heartbeat_rate);
				return;
			end
			want = expected_status.pop_front();
			if (got.status !== want.status) begin
				failures++;
				$display("%0t ns: status expected %0d, actual %0d", $time, want.status, got.status);
			end
			if (got.mode_now !== want.mode_now) begin
				failures++;
				$display("%0t ns: mode_now expected %0d, actual %0d",
					$time, want.mode_now, got.mode_now);
			end
			if (got.heartbeat_rate !== want.heartbeat_rate) begin
				failures++;
				$display("%0t ns: heartbeat_rate expected %0d, actual %0d",
					$time, want.heartbeat_rate, got.heartbeat_rate);
			end
		endfunction

		function int pending_count();
			return expected_status.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [7:0]  cfg_data;

	packet_status_checker board;
	logic [7:0]           pkt_bytes[$];
	int                   chars_sent;

	text_command_packet_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Sample both handshakes at the rising edge; stimulus only moves on the falling edge,
	// so everything read here is settled. Check before noting: a result can never belong
	// to a word accepted on the same edge, so the order does not matter.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_status(out_data);
		if (arst_n && in_valid && in_ready) board.note_char(in_data);
	end

	// Flip upper-case letters to lower case at random; the block folds case on commands
	// and on the prefix, so both spellings must give the same answer.
	function automatic logic [7:0] letter_case(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	// Characters that steer the parser: separators, dots, digits, or any byte at all.
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return CHAR_SPACE;
			1: return CHAR_DOT;
			2: return 8'h30 + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Any non-space byte, high bytes included, for the UUID and value tokens.
	function automatic logic [7:0] token_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CHAR_SPACE) ? 8'h21 : c;
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
	endfunction

	function automatic void put_prefix();
		for (int i = 0; i < 4; i++) pkt_bytes.push_back(letter_case(PROTO_PREFIX[31 - 8 * i -: 8]));
	endfunction

	// One version number: mostly the programmed value so that matches happen, otherwise
	// random, saturating, empty or single digit, sometimes with a leading zero and
	// sometimes followed by a non-digit and more digits that must be ignored.
	function automatic void put_version_part(logic [7:0] want);
		int v;
		logic [7:0] junk;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = want;
			6: v = $urandom_range(0, 255);
			7: v = $urandom_range(0, 1) ? 256 + $urandom_range(0, 1) : $urandom_range(258, 99999);
			8: v = -1;
			default: v = $urandom_range(0, 9);
		endcase
		if (v >= 0) begin
			if ($urandom_range(0, 7) == 0) pkt_bytes.push_back(8'h30);
			put_text($sformatf("%0d", v));
		end
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 2))
				0: junk = 8'h2F;
				1: junk = 8'h3A;
				default: junk = token_byte();
			endcase
			pkt_bytes.push_back(junk);
			if ($urandom_range(0, 1) == 1) put_text($sformatf("%0d", $urandom_range(0, 99)));
		end
	endfunction

	// Build one packet into pkt_bytes. Most packets are well formed with random content,
	// some carry a wrong-length command, some get a single corruption, and a few are
	// pure noise.
	function automatic void build_packet(logic [7:0] want_major, logic [7:0] want_minor);
		int          kind;
		int          n;
		int          pos;
		logic [31:0] cmd;
		pkt_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 16);
			repeat (n) pkt_bytes.push_back(noise_byte());
			return;
		end
		case ($urandom_range(0, 8))
			0: cmd = CMD_LIST;
			1: cmd = CMD_GETV;
			2: cmd = CMD_GETM;
			3: cmd = CMD_GETP;
			4: cmd = CMD_SETV;
			5: cmd = CMD_SETM;
			6: cmd = CMD_SETP;
			// letters plus the bytes just outside the letter ranges
			default: cmd = {8'($urandom_range(8'h40, 8'h7B)), 8'($urandom_range(8'h40, 8'h7B)),
				8'($urandom_range(8'h40, 8'h7B)), 8'($urandom_range(8'h40, 8'h7B))};
		endcase
		if (kind < 14) begin
			n = $urandom_range(0, 6);
			if (n == 4) n = 5;
			repeat (n) pkt_bytes.push_back(letter_case(8'h41 + 8'($urandom_range(0, 25))));
		end else begin
			for (int i = 0; i < 4; i++) pkt_bytes.push_back(letter_case(cmd[31 - 8 * i -: 8]));
		end
		pkt_bytes.push_back(CHAR_SPACE);
		if (cmd != CMD_LIST) begin
			n = $urandom_range(1, 6);
			repeat (n) pkt_bytes.push_back(token_byte());
			pkt_bytes.push_back(CHAR_SPACE);
			if (cmd != CMD_GETV && cmd != CMD_GETM && cmd != CMD_GETP) begin
				n = $urandom_range(1, 4);
				repeat (n) pkt_bytes.push_back(token_byte());
				pkt_bytes.push_back(CHAR_SPACE);
			end
		end
		put_prefix();
		put_version_part(want_major);
		if ($urandom_range(0, 19) != 0) pkt_bytes.push_back(CHAR_DOT);
		put_version_part(want_minor);
		if (kind >= 80) begin
			pos = $urandom_range(0, pkt_bytes.size() - 1);
			case ($urandom_range(0, 3))
				0: pkt_bytes[pos] = noise_byte();
				1: if (pkt_bytes.size() > 1) pkt_bytes.delete(pos);
				2: while (pkt_bytes.size() > pos + 1) pkt_bytes.pop_back();
				default: pkt_bytes.insert(pos, CHAR_SPACE);
			endcase
		end
	endfunction

	// Send pkt_bytes one word per handshake, the final word flagged as last. A word is
	// held with valid high and payload steady until it is taken. Some packets go out
	// back to back with no gaps; the others may insert an idle gap, valid low, before every word.
	task automatic send_packet();
		bit quiet;
		int gap;
		quiet = ($urandom_range(0, 4) == 0);
		foreach (pkt_bytes[i]) begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			in_valid <= 1'b1;
			in_data.char_byte <= pkt_bytes[i];
			in_data.last_char <= (i == pkt_bytes.size() - 1);
			do @(posedge clk); while (!in_ready);
			chars_sent++;
		end
	endtask

	// Drop valid, hold off until every expected status has come back, then let the
	// output register settle before anything touches the configuration.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both version registers on consecutive edges; the block is idle here.
	task automatic program_version(logic [7:0] maj, logic [7:0] min);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VERSION_MAJOR;
		cfg_data <= maj;
		@(posedge clk);
		board.set_version(CFG_VERSION_MAJOR, maj);
		@(negedge clk);
		cfg_index <= CFG_VERSION_MINOR;
		cfg_data <= min;
		@(posedge clk);
		board.set_version(CFG_VERSION_MINOR, min);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: ready may be held low before each result, with stretches where
	// ready stays high throughout. A stall while a result is pending makes the block
	// drop in_ready, which in turn holds the sender.
	initial begin
		int stall;
		bit steady;
		out_ready = 1'b0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0) steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Main sequence: reset, a few directed packets, then random phases under
	// different version settings, each closed by a full drain.
	initial begin
		int p;
		int phase_start;
		board = new();
		chars_sent = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_VERSION_MAJOR;
		cfg_data = 8'd0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// NUL and all-ones bytes as a whole packet: both end far too early
		pkt_bytes.delete();
		pkt_bytes.push_back(8'h00);
		send_packet();
		pkt_bytes.delete();
		pkt_bytes.push_back(8'hFF);
		send_packet();
		// empty command token
		pkt_bytes.delete();
		put_text(" ");
		send_packet();
		// mixed-case command that switches to heartbeat mode, version matches reset value
		pkt_bytes.delete();
		put_text("gEtP a ");
		put_prefix();
		put_text("0.1");
		send_packet();
		// command without UUID, minor version off by one
		pkt_bytes.delete();
		put_text("LIST ");
		put_prefix();
		put_text("0.2");
		send_packet();
		drain();

		for (p = 0; p < 6; p++) begin
			// keep reset values first, then the extremes, then assorted settings
			case (p)
				0: ;
				1: program_version(8'd0, 8'd0);
				2: program_version(8'd255, 8'd255);
				3: program_version(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				4: program_version(8'd1, 8'd0);
				default: program_version(8'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
			endcase
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				build_packet(board.exp_major, board.exp_minor);
				send_packet();
			end
			drain();
		end

		if (board.failures == 0 && board.pending_count() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
